// ===== rtl/core/lzsswd_pkg.sv =====
// ============================================================================
// lzsswd_pkg
// Shared constants and types for the LZSS window decoder.
// ============================================================================
`timescale 1ns / 1ps

package lzsswd_pkg;

    localparam int WINDOW_SIZE = 4096;   // history window depth in bytes
    localparam int CMD_DEPTH   = 2;      // front-to-back command queue
    localparam int OUT_DEPTH   = 4;      // result queue

    localparam int LEN_W  = 24;          // output_length / byte counter width
    localparam int POS_W  = 12;          // window position field of a match
    localparam int MLEN_W = 4;           // match length code
    localparam int LEFT_W = 5;           // bytes left in a run, up to 18

    localparam logic [POS_W-1:0]  START_POS  = 12'hFEE;
    localparam logic [15:0]       FLAG_GUARD = 16'hFF00;
    localparam logic [LEFT_W-1:0] MATCH_BIAS = 5'd3;
    localparam logic [LEN_W-1:0]  OUT_LEN_RESET = 24'd1;

    // One decoded token, handed from the front to the back.
    typedef struct packed {
        logic              start;      // first token of a new stream
        logic              is_match;   // 0: literal in pos[7:0]
        logic [POS_W-1:0]  pos;
        logic [MLEN_W-1:0] len;
    } t_cmd;

    // One result word.
    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       stream_end;
    } t_res;

endpackage

// ===== rtl/core/lzsswd_fifo.sv =====
// ============================================================================
// lzsswd_fifo
// Small register-based FIFO with occupancy count.
// ============================================================================
`timescale 1ns / 1ps

module lzsswd_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [W-1:0]                 o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          s_push, s_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];

    assign s_push = i_push && !o_full;
    assign s_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (s_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (s_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        case ({s_push, s_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/core/lzsswd_front.sv =====
// ============================================================================
// lzsswd_front
// Token parser: walks flag bits and turns input bytes into literal/match
// commands.
// ============================================================================
`timescale 1ns / 1ps

module lzsswd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  logic [7:0]           i_byte,
    input  logic                 i_start,
    output logic                 o_cmd_push,
    output lzsswd_pkg::t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        PH_FLAG = 4'b0001,
        PH_LIT  = 4'b0010,
        PH_MLO  = 4'b0100,
        PH_MHI  = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase, s_phase, s_after;
    logic [15:0] r_ctrl, n_ctrl, s_ctrl, s_shift;
    logic [7:0]  r_mlo, n_mlo;
    logic        r_start_pend, n_start_pend;

    // Stream start restarts parsing with this byte as the flag byte.
    assign s_phase = i_start ? PH_FLAG : r_phase;
    assign s_ctrl  = i_start ? 16'h0000 : r_ctrl;

    // Next token from the remaining control bits; guard bits mark exhaustion.
    assign s_shift = {1'b0, s_ctrl[15:1]};
    always_comb begin
        if (!s_shift[8]) begin
            s_after = PH_FLAG;
        end else if (s_shift[0]) begin
            s_after = PH_LIT;
        end else begin
            s_after = PH_MLO;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_ctrl       = r_ctrl;
        n_mlo        = r_mlo;
        n_start_pend = r_start_pend || (i_acc && i_start);
        o_cmd_push   = 1'b0;
        o_cmd.start    = r_start_pend;
        o_cmd.is_match = 1'b0;
        o_cmd.pos      = {{(lzsswd_pkg::POS_W - 8){1'b0}}, i_byte};
        o_cmd.len      = i_byte[3:0];
        if (i_acc) begin
            n_ctrl = s_ctrl;
            case (s_phase)
                PH_FLAG: begin
                    n_ctrl  = {8'h00, i_byte} | lzsswd_pkg::FLAG_GUARD;
                    n_phase = i_byte[0] ? PH_LIT : PH_MLO;
                end
                PH_LIT: begin
                    o_cmd_push   = 1'b1;
                    n_ctrl       = s_shift;
                    n_phase      = s_after;
                    n_start_pend = 1'b0;
                end
                PH_MLO: begin
                    n_mlo   = i_byte;
                    n_phase = PH_MHI;
                end
                PH_MHI: begin
                    o_cmd_push     = 1'b1;
                    o_cmd.is_match = 1'b1;
                    o_cmd.pos      = {i_byte[7:4], r_mlo};
                    n_ctrl         = s_shift;
                    n_phase        = s_after;
                    n_start_pend   = 1'b0;
                end
                default: begin
                    n_phase = PH_FLAG;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAG;
            r_ctrl       <= '0;
            r_mlo        <= '0;
            r_start_pend <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_ctrl       <= n_ctrl;
            r_mlo        <= n_mlo;
            r_start_pend <= n_start_pend;
        end
    end

endmodule

// ===== rtl/core/lzsswd_back.sv =====
// ============================================================================
// lzsswd_back
// Copy engine: history window, one byte per cycle while the result queue has room, end-of-stream tracking.
// ============================================================================
`timescale 1ns / 1ps

module lzsswd_back #(
    parameter int WINDOW_SIZE = lzsswd_pkg::WINDOW_SIZE,
    parameter int OUT_DEPTH   = lzsswd_pkg::OUT_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [lzsswd_pkg::LEN_W-1:0]      i_out_len,
    input  lzsswd_pkg::t_cmd                  i_cmd,
    input  logic                              i_cmd_empty,
    output logic                              o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]    i_out_count,
    output logic                              o_res_push,
    output lzsswd_pkg::t_res                  o_res
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam logic [AW-1:0] WIN_START = AW'(lzsswd_pkg::START_POS);
    localparam logic [AW:0]   FILL_MAX  = (AW+1)'(WINDOW_SIZE);

    typedef enum logic [1:0] {
        SRC_LIT  = 2'd0,
        SRC_MEM  = 2'd1,
        SRC_FWD  = 2'd2,
        SRC_ZERO = 2'd3
    } t_src;

    logic [7:0] r_win [WINDOW_SIZE];
    logic [7:0] r_rdata;

    // issue stage
    logic                                r_busy;
    logic                                r_is_match;
    logic [AW-1:0]                       r_src;
    logic [lzsswd_pkg::LEFT_W-1:0]       r_left;
    logic [7:0]                          r_lit;
    logic [AW-1:0]                       r_wp;
    logic [AW:0]                         r_fill;
    logic [lzsswd_pkg::LEN_W-1:0]        r_prod;
    logic                                r_fin;

    // data stage
    logic          r_d_vld;
    t_src          r_d_sel;
    logic [7:0]    r_d_byte;
    logic [AW-1:0] r_d_waddr;
    logic          r_d_we;
    logic          r_d_last;
    logic          r_d_end;

    logic                          s_credit, s_issue, s_end, s_last;
    logic                          s_written, s_fwd, s_we;
    logic [AW-1:0]                 s_off;
    logic [lzsswd_pkg::LEN_W-1:0]  s_prod_n;
    logic [7:0]                    s_dbyte;
    t_src                          s_sel;

    // data stage byte
    always_comb begin
        case (r_d_sel)
            SRC_LIT, SRC_FWD: s_dbyte = r_d_byte;
            SRC_MEM:          s_dbyte = r_rdata;
            default:          s_dbyte = 8'h00;
        endcase
    end

    assign s_we       = r_d_vld && r_d_we;
    assign o_res_push = r_d_vld;
    assign o_res.data       = s_dbyte;
    assign o_res.run_last   = r_d_last;
    assign o_res.stream_end = r_d_end;

    // keep room in the result queue for the byte in the data stage
    assign s_credit = ({1'b0, i_out_count} + (CW+1)'(r_d_vld)) < (CW+1)'(OUT_DEPTH);
    assign s_issue  = r_busy && s_credit;
    assign o_cmd_pop = !r_busy && !i_cmd_empty;

    assign s_prod_n = r_prod + 1'b1;
    assign s_end    = (s_prod_n >= i_out_len);
    assign s_last   = (r_left == lzsswd_pkg::LEFT_W'(1)) || s_end;

    // entries written since stream start lie in [START, START + fill)
    assign s_off     = r_src - WIN_START;
    assign s_written = ({1'b0, s_off} < r_fill);
    assign s_fwd     = s_we && (r_d_waddr == r_src);

    always_comb begin
        if (!r_is_match) begin
            s_sel = SRC_LIT;
        end else if (s_fwd) begin
            s_sel = SRC_FWD;
        end else if (s_written) begin
            s_sel = SRC_MEM;
        end else begin
            s_sel = SRC_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_wp    <= WIN_START;
            r_fill  <= '0;
            r_prod  <= '0;
            r_fin   <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= s_issue;
            if (o_cmd_pop) begin
                if (i_cmd.start) begin
                    r_wp   <= WIN_START;
                    r_prod <= '0;
                    r_fin  <= 1'b0;
                end
                r_busy <= i_cmd.start || !r_fin;
            end else if (s_issue) begin
                r_prod <= s_prod_n;
                r_fin  <= s_end;
                if (!s_end) begin
                    r_wp <= r_wp + 1'b1;
                end
                if (s_last) begin
                    r_busy <= 1'b0;
                end
            end
            // a new stream forgets everything in the window
            if (o_cmd_pop && i_cmd.start) begin
                r_fill <= '0;
            end else if (s_we && (r_fill != FILL_MAX)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // command load and per-byte payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_is_match <= i_cmd.is_match;
            r_src      <= AW'(i_cmd.pos);
            r_lit      <= i_cmd.pos[7:0];
            r_left     <= i_cmd.is_match
                          ? lzsswd_pkg::LEFT_W'(i_cmd.len) + lzsswd_pkg::MATCH_BIAS
                          : lzsswd_pkg::LEFT_W'(1);
        end else if (s_issue) begin
            r_src  <= r_src + 1'b1;
            r_left <= r_left - 1'b1;
        end
        if (s_issue) begin
            r_d_sel   <= s_sel;
            r_d_byte  <= r_is_match ? s_dbyte : r_lit;
            r_d_waddr <= r_wp;
            r_d_we    <= !s_end;
            r_d_last  <= s_last;
            r_d_end   <= s_end;
        end
    end

    // history window: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (s_issue && r_is_match) begin
            r_rdata <= r_win[r_src];
        end
        if (s_we) begin
            r_win[r_d_waddr] <= s_dbyte;
        end
    end

endmodule

// ===== rtl/core/lzsswd_top_note.sv =====
// ============================================================================
// lzsswd_check
// Port-side sanity checks on the result queue interface.
// ============================================================================
`timescale 1ns / 1ps

module lzsswd_check (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  logic i_stream_end,
    input  logic i_run_last
);

    // A stream's final word always closes the run of its input word.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_stream_end) |-> i_run_last)
        else $error("stream_end word without run_last");

endmodule

// ===== rtl/core/lzss_window_decoder.sv =====
// ============================================================================
// lzss_window_decoder
// Classic LZSS decompressor: 4096-byte history, 12-bit position, 4-bit length.
//
// Compressed bytes go in through a queue-style port (push/full) and decoded
// bytes come out through a queue-style port (empty/pop), one byte per word.
// A flag byte gives eight control bits, LSB first: 1 = literal byte,
// 0 = two-byte match (position = low byte | high nibble of second byte << 8,
// length = low nibble + 3). stream_start on an input word clears the window
// and decoder state; that word is the first flag byte. After output_length
// bytes the stream ends (stream_end on that word) and further input is
// swallowed without results until the next stream start.
// Timing: a front parser takes one input byte per cycle while its 2-entry
// command queue has room; flag and match-low bytes give no result. The copy
// engine loads a command and then, while the result queue has room, emits
// one byte per cycle through the window's one read port; each byte passes
// an issue stage and a data stage on its way to the result queue. The window
// needs no clearing pass: a fill count marks which entries the current
// stream has written, others read as zero.
// ============================================================================
`timescale 1ns / 1ps

module lzss_window_decoder #(
    parameter int WINDOW_SIZE = lzsswd_pkg::WINDOW_SIZE,
    parameter int CMD_DEPTH   = lzsswd_pkg::CMD_DEPTH,
    parameter int OUT_DEPTH   = lzsswd_pkg::OUT_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // compressed input
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_stream_start,
    // decoded output
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_stream_end,
    // output_length register
    input  logic                          i_cfg_we,
    input  logic [lzsswd_pkg::LEN_W-1:0]  i_cfg_wdata
);

    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam int KCW = $clog2(CMD_DEPTH + 1);

    logic [lzsswd_pkg::LEN_W-1:0] r_out_len;

    logic              s_acc;
    logic              s_cmd_push, s_cmd_full, s_cmd_empty, s_cmd_pop;
    lzsswd_pkg::t_cmd  s_cmd_in, s_cmd_out;
    logic [KCW-1:0]    s_cmd_count;

    logic              s_res_push, s_res_full;
    lzsswd_pkg::t_res  s_res_in, s_res_out;
    logic [OCW-1:0]    s_res_count;

    // Config register; the user must write it only while the decoder is idle, the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_len <= lzsswd_pkg::OUT_LEN_RESET;
        end else if (i_cfg_we) begin
            r_out_len <= i_cfg_wdata;
        end
    end

    // Input is held off whenever the command queue is full.
    assign full  = s_cmd_full;
    assign s_acc = push && !full;

    lzsswd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (s_acc),
        .i_byte     (i_in_byte),
        .i_start    (i_stream_start),
        .o_cmd_push (s_cmd_push),
        .o_cmd      (s_cmd_in)
    );

    // Decouples parsing from copying so a long match does not stall the input
    // until the queue fills.
    lzsswd_fifo #(
        .W     ($bits(lzsswd_pkg::t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_cmd_push),
        .i_data  (s_cmd_in),
        .o_full  (s_cmd_full),
        .i_pop   (s_cmd_pop),
        .o_data  (s_cmd_out),
        .o_empty (s_cmd_empty),
        .o_count (s_cmd_count)
    );

    lzsswd_back #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .OUT_DEPTH   (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_out_len   (r_out_len),
        .i_cmd       (s_cmd_out),
        .i_cmd_empty (s_cmd_empty),
        .o_cmd_pop   (s_cmd_pop),
        .i_out_count (s_res_count),
        .o_res_push  (s_res_push),
        .o_res       (s_res_in)
    );

    // Result queue; the copy engine reserves space before each window read.
    lzsswd_fifo #(
        .W     ($bits(lzsswd_pkg::t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_push),
        .i_data  (s_res_in),
        .o_full  (s_res_full),
        .i_pop   (pop),
        .o_data  (s_res_out),
        .o_empty (empty),
        .o_count (s_res_count)
    );

    assign o_out_byte   = s_res_out.data;
    assign o_run_last   = s_res_out.run_last;
    assign o_stream_end = s_res_out.stream_end;

    lzsswd_check u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_stream_end (o_stream_end),
        .i_run_last   (o_run_last)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Credit check in the copy engine must never overrun the result queue.
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_res_push |-> (!s_res_full || pop))
        else $error("result queue overrun");

    // Parser never pushes a command the queue cannot take.
    a_cmd_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd_push |-> (s_cmd_count != KCW'(CMD_DEPTH)))
        else $error("command queue overrun");

    // Both queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the LZSS window decoder.
//
// Compressed words go in through the push/full port and decoded bytes come
// back through empty/pop. A scoreboard object decodes every accepted input
// word on its own copy of the history window and queues the bytes it
// expects. Each popped byte is checked field by field against the oldest
// one in that queue.
// The stimulus starts with a directed block: reset length, zero length, the
// largest length, overlapping matches, a length lowered mid-stream,
// swallowed input after the end, and a stream start in the middle of a
// match. After that come random streams of well-formed tokens with some
// noise and broken streams mixed in. Both sides stall at random, and there
// is one long receiver hold-off that backs the block up into its input.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF     = 4;         // 8 ns period
    localparam int RESET_CYCLES = 12;
    localparam int LIMIT_CYCLES = 400000;    // far above the slowest legal run
    localparam int DRAIN_PAD    = 40;        // quiet cycles before reg writes / end
    localparam int HOLD_CYCLES  = 300;       // long receiver hold-off
    localparam int RANDOM_WORDS = 140;       // accepted words in the random part
    localparam int MAX_REPORTS  = 10;
    localparam logic [lzsswd_pkg::LEN_W-1:0] LEN_MAX = 24'hFFFFFF;

    // Where the decoder is within the token stream.
    typedef enum logic [1:0] {TK_FLAG, TK_LIT, TK_MLO, TK_MHI} t_token;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow decoder plus the queue of bytes still to come out.
    // ------------------------------------------------------------------------
    class byte_tracker;
        logic [7:0]                   hist [lzsswd_pkg::WINDOW_SIZE];
        logic [lzsswd_pkg::POS_W-1:0] wr_pos;
        logic [15:0]                  ctrl;
        t_token                       phase;
        logic [7:0]                   match_lo;
        logic [lzsswd_pkg::LEN_W-1:0] produced;
        logic [lzsswd_pkg::LEN_W-1:0] out_len;
        bit                           done;
        lzsswd_pkg::t_res             expected_bytes [$];
        int                           errors;
        int                           checked;
        int                           reported;

        function new();
            out_len  = lzsswd_pkg::OUT_LEN_RESET;
            errors   = 0;
            checked  = 0;
            reported = 0;
            clear();
        endfunction

        function void clear();
            foreach (hist[i]) hist[i] = '0;
            wr_pos   = lzsswd_pkg::START_POS;
            ctrl     = '0;
            phase    = TK_FLAG;
            match_lo = '0;
            produced = '0;
            done     = 1'b0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void note_error(string msg);
            errors++;
            if (reported < MAX_REPORTS) begin
                $display("%s", msg);
                reported++;
            end
        endfunction

        // One decoded byte; returns 1 when it ends the stream.
        // The ending byte is never written back into the window.
        function bit emit(logic [7:0] d);
            lzsswd_pkg::t_res r;
            r.data       = d;
            r.run_last   = 1'b0;
            r.stream_end = 1'b0;
            produced     = produced + 1'b1;
            if (produced >= out_len) begin
                r.stream_end = 1'b1;
                done         = 1'b1;
                expected_bytes.push_back(r);
                return 1'b1;
            end
            expected_bytes.push_back(r);
            hist[wr_pos] = d;
            wr_pos       = wr_pos + 1'b1;
            return 1'b0;
        endfunction

        // Shift to the next control bit; guard bits run out after eight.
        function void advance();
            ctrl = ctrl >> 1;
            if (!ctrl[8])
                phase = TK_FLAG;
            else if (ctrl[0])
                phase = TK_LIT;
            else
                phase = TK_MLO;
        endfunction

        // Decode one accepted word; returns 0 if it was swallowed after the end.
        function bit decode_word(logic [7:0] b, logic start);
            int                           prior;
            int                           n;
            bit                           fin;
            logic [lzsswd_pkg::POS_W-1:0] rd;
            lzsswd_pkg::t_res             r;
            if (start)
                clear();
            if (done)
                return 1'b0;
            prior = expected_bytes.size();
            case (phase)
                TK_FLAG: begin
                    ctrl  = lzsswd_pkg::FLAG_GUARD | {8'h00, b};
                    phase = ctrl[0] ? TK_LIT : TK_MLO;
                end
                TK_LIT: begin
                    if (!emit(b))
                        advance();
                end
                TK_MLO: begin
                    match_lo = b;
                    phase    = TK_MHI;
                end
                default: begin
                    // byte-at-a-time copy, so overlapping matches read fresh data
                    rd  = {b[7:4], match_lo};
                    n   = int'(b[3:0]) + 3;
                    fin = 1'b0;
                    for (int i = 0; i < n && !fin; i++) begin
                        fin = emit(hist[rd]);
                        rd  = rd + 1'b1;
                    end
                    if (!fin)
                        advance();
                end
            endcase
            if (expected_bytes.size() > prior) begin
                r          = expected_bytes.pop_back();
                r.run_last = 1'b1;
                expected_bytes.push_back(r);
            end
            return 1'b1;
        endfunction

        function void check_byte(lzsswd_pkg::t_res got);
            lzsswd_pkg::t_res want;
            if (expected_bytes.size() == 0) begin
                note_error($sformatf("unexpected byte %02h (last %0b end %0b), none pending",
                                     got.data, got.run_last, got.stream_end));
                return;
            end
            want = expected_bytes.pop_front();
            checked++;
            if (got.data !== want.data || got.run_last !== want.run_last ||
                got.stream_end !== want.stream_end)
                note_error($sformatf(
                    "byte %0d: expected data %02h last %0b end %0b, got data %02h last %0b end %0b",
                    checked, want.data, want.run_last, want.stream_end,
                    got.data, got.run_last, got.stream_end));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals; every block input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                         i_clk          = 1'b0;
    logic                         i_rst_n        = 1'b0;
    logic                         push           = 1'b0;
    logic                         full;
    logic [7:0]                   i_in_byte      = '0;
    logic                         i_stream_start = 1'b0;
    logic                         empty;
    logic                         pop            = 1'b0;
    logic [7:0]                   o_out_byte;
    logic                         o_run_last;
    logic                         o_stream_end;
    logic                         i_cfg_we       = 1'b0;
    logic [lzsswd_pkg::LEN_W-1:0] i_cfg_wdata    = '0;

    byte_tracker board;
    int  cycles      = 0;
    int  words_in    = 0;   // every accepted word
    int  live_words  = 0;   // accepted words that reached the decoder
    int  starts_seen = 0;
    int  len_writes  = 0;
    int  send_idle   = 0;   // percent of cycles the sender holds back
    int  recv_idle   = 0;   // percent of cycles the receiver holds back
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  base;

    lzss_window_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_stream_end   (o_stream_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Run guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d bytes still pending",
                     cycles, board.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Both handshakes are sampled at the rising edge; drives move on the
    // falling edge, so the sampled values are settled.
    always @(posedge i_clk) begin : watch
        lzsswd_pkg::t_res got;
        if (i_rst_n) begin
            if (push && !full) begin
                words_in++;
                if (i_stream_start)
                    starts_seen++;
                if (board.decode_word(i_in_byte, i_stream_start))
                    live_words++;
            end
            if (pop && !empty) begin
                got.data       = o_out_byte;
                got.run_last   = o_run_last;
                got.stream_end = o_stream_end;
                board.check_byte(got);
            end
        end
    end

    // Receiver: random pop, or a long counted hold-off when asked for one.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
        end else begin
            pop = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. Called at a falling edge, returns at a falling edge with
    // push already low, so back-to-back calls keep push steady high.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic s);
        while ($urandom_range(0, 99) < send_idle) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push           = 1'b1;
        i_in_byte      = b;
        i_stream_start = s;
        do
            @(posedge i_clk);
        while (full);
        @(negedge i_clk);
        push = 1'b0;
    endtask

    // All expected bytes out, then enough quiet cycles for any swallowed or
    // byte-less words still in flight inside the block.
    task automatic wait_idle();
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (DRAIN_PAD) @(negedge i_clk);
    endtask

    task automatic set_length(input logic [lzsswd_pkg::LEN_W-1:0] v);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        board.out_len = v;
        len_writes++;
    endtask

    // Well-formed stream of random tokens; now and then cut off mid-match.
    task automatic random_stream();
        int                           ntok;
        bit                           broken;
        logic [7:0]                   flag;
        logic [lzsswd_pkg::POS_W-1:0] pos;
        logic [3:0]                   code;
        ntok   = $urandom_range(1, 24);
        broken = ($urandom_range(0, 9) == 0);
        flag   = 8'($urandom_range(0, 255));
        send_word(flag, 1'b1);
        for (int t = 0; t < ntok; t++) begin
            if (t > 0 && t % 8 == 0) begin
                flag = 8'($urandom_range(0, 255));
                send_word(flag, 1'b0);
            end
            if (flag[t % 8]) begin
                send_word(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                // mostly just behind the write pointer, so overlaps are common
                if ($urandom_range(0, 3) == 0)
                    pos = 12'($urandom_range(0, 4095));
                else
                    pos = board.wr_pos - 12'($urandom_range(1, 20));
                code = 4'($urandom_range(0, 15));
                send_word(pos[7:0], 1'b0);
                if (broken && t == ntok - 1)
                    return;
                send_word({pos[11:8], code}, 1'b0);
            end
        end
    endtask

    // Unstructured bytes with the odd stream start.
    task automatic noise_words();
        int n;
        n = $urandom_range(3, 12);
        repeat (n)
            send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 5) == 0));
    endtask

    function automatic logic [lzsswd_pkg::LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0:       return 24'd1;
            1:       return LEN_MAX;
            2:       return 24'd0;     // behaves as one byte
            default: return 24'($urandom_range(2, 60));
        endcase
    endfunction

    initial begin
        board     = new();
        send_idle = 32;
        recv_idle = 53;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // --- reset length of one: a literal ends the stream at once,
        //     the next word is swallowed
        send_word(8'h01, 1'b1);
        send_word(8'h41, 1'b0);
        send_word(8'h7E, 1'b0);

        // --- zero length: an 18-byte match still gives exactly one byte
        set_length(24'd0);
        send_word(8'hFE, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);

        // --- largest length; flag F3 = lit, lit, match, match, 4 x lit.
        //     The first match starts two bytes behind the write pointer (overlapping copy,
        //     longest run), the second reads the wrapped entries at 0.
        set_length(LEN_MAX);
        send_word(8'hF3, 1'b1);
        send_word(8'hAB, 1'b0);
        send_word(8'hCD, 1'b0);
        send_word(8'hEE, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);

        // --- length lowered below the byte count mid-stream: the next
        //     byte ends it, and what follows is swallowed
        set_length(24'd5);
        send_word(8'h01, 1'b0);
        send_word(8'h77, 1'b0);
        send_word(8'h12, 1'b0);

        // --- stream start lands between the two match bytes
        send_word(8'h00, 1'b1);
        send_word(8'h34, 1'b0);
        send_word(8'h80, 1'b1);

        // --- back-pressure: long receiver hold-off while the sender keeps
        //     offering literals, then the sender waits for the backlog
        set_length(LEN_MAX);
        hold_req = 1'b1;
        for (int k = 0; k < 18; k++) begin
            if (k % 9 == 0)
                send_word(8'hFF, (k == 0));
            else
                send_word(8'($urandom_range(0, 255)), 1'b0);
        end
        wait_idle();

        // --- random streams; idling swaps sides after each third, the last
        //     third runs with no idling at all
        base = words_in;
        while (words_in - base < RANDOM_WORDS) begin
            if (words_in - base < RANDOM_WORDS / 3) begin
                send_idle = 32;
                recv_idle = 53;
            end else if (words_in - base < 2 * RANDOM_WORDS / 3) begin
                send_idle = 53;
                recv_idle = 32;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if ($urandom_range(0, 9) < 6)
                set_length(pick_length());
            if ($urandom_range(0, 9) == 0)
                noise_words();
            else
                random_stream();
        end

        // drain; the run guard catches a block that never finishes
        wait_idle();
        if (board.pending() != 0)
            board.note_error($sformatf("%0d expected bytes never came out",
                                       board.pending()));

        $display("Sent %0d compressed words (%0d decoded, rest after stream end),",
                 words_in, live_words);
        $display("%0d bytes checked across %0d stream starts and %0d length settings.",
                 board.checked, starts_seen, len_writes);
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
